[sv/assert_macros.svh]
// Assertion macros shared by the scheduler RTL.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define TSS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TSS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TSS_ASSERT_IMP(lbl, ante, cons, msg)

`define TSS_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

[sv/tss_pkg.sv]
// Types and constants for the TDMA slot scheduler.
// No dependencies; used by tss_cfg, tss_step and tdma_slot_scheduler.
`default_nettype none

package tss_pkg;

    // Event kinds carried in the input tuser
    typedef logic [1:0] t_op;
    localparam t_op OP_SUPERCYCLE = 2'd0;
    localparam t_op OP_MATCH      = 2'd1;
    localparam t_op OP_PACKET     = 2'd2;

    // Radio commands
    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_NONE  = 2'd0;
    localparam t_cmd CMD_TX    = 2'd1;
    localparam t_cmd CMD_RX    = 2'd2;
    localparam t_cmd CMD_SLEEP = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W   = 3;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_NODE_ID     = 3'd0;
    localparam t_cfg_idx REG_SLOT_TICKS  = 3'd1;
    localparam t_cfg_idx REG_SLOT_COUNT  = 3'd2;
    localparam t_cfg_idx REG_CYCLE_COUNT = 3'd3;
    localparam t_cfg_idx REG_KEEP_CYCLES = 3'd4;

    // Reset values of the registers and of the products derived from them
    localparam logic [7:0]  RST_NODE_ID     = 8'd0;
    localparam logic [15:0] RST_SLOT_TICKS  = 16'd100;
    localparam logic [7:0]  RST_SLOT_COUNT  = 8'd4;
    localparam logic [7:0]  RST_CYCLE_COUNT = 8'd4;
    localparam logic [15:0] RST_KEEP_CYCLES = 16'd10;
    localparam logic [15:0] RST_SCCC        = 16'd16;
    localparam logic [15:0] RST_NID_TICKS   = 16'd0;
    localparam logic [23:0] RST_SPAN_TICKS  = 24'd300;
    localparam logic [23:0] RST_SC_TICKS    = 24'd400;
    localparam logic [31:0] RST_TOTAL_TICKS = 32'd1600;

    // Air delay added to a received packet time
    localparam logic [15:0] PKT_DELAY_TICKS = 16'd27;

    // Configuration as seen by the event logic
    typedef struct packed {
        logic [7:0]  node_id;
        logic [15:0] slot_ticks;
        logic [15:0] keep_cycles;
        logic [15:0] nid_ticks;    // slot_ticks * node_id, low bits
        logic [23:0] span_ticks;   // slot_ticks * (slot_count - 1)
        logic [23:0] sc_ticks;     // slot_ticks * slot_count
        logic [31:0] total_ticks;  // slot_ticks * slot_count * cycle_count
    } t_cfg;

    typedef struct packed {
        t_op         op;
        logic [15:0] tick;
        logic [7:0]  pkt_sender;
        logic [7:0]  pkt_source;
        logic [15:0] pkt_time;
    } t_item;

    typedef struct packed {
        t_cmd        command;
        logic        compare_write;
        logic [15:0] compare_value;
        logic        counter_write;
        logic [15:0] counter_value;
        logic [7:0]  source_id;
    } t_result;

endpackage

`default_nettype wire

[sv/tss_cfg.sv]
// Configuration registers of the slot scheduler and the slot products derived from them.
// Depends on tss_pkg.
`default_nettype none

module tss_cfg (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire tss_pkg::t_cfg_idx     i_cfg_idx,
    input  wire logic [15:0]           i_cfg_data,
    output tss_pkg::t_cfg              o_cfg
);
    import tss_pkg::*;

    logic [7:0]  r_node_id,     n_node_id;
    logic [15:0] r_slot_ticks,  n_slot_ticks;
    logic [7:0]  r_slot_count,  n_slot_count;
    logic [7:0]  r_cycle_count, n_cycle_count;
    logic [15:0] r_keep_cycles, n_keep_cycles;
    logic [15:0] r_sccc;
    logic [15:0] r_nid_ticks;
    logic [23:0] r_span_ticks;
    logic [23:0] r_sc_ticks;
    logic [31:0] r_total_ticks;
    logic [7:0]  w_span;
    logic [23:0] w_nid_prod;

    // Decode the write port
    always_comb begin
        n_node_id     = r_node_id;
        n_slot_ticks  = r_slot_ticks;
        n_slot_count  = r_slot_count;
        n_cycle_count = r_cycle_count;
        n_keep_cycles = r_keep_cycles;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_NODE_ID:     n_node_id     = i_cfg_data[7:0];
                REG_SLOT_TICKS:  n_slot_ticks  = i_cfg_data;
                REG_SLOT_COUNT:  n_slot_count  = i_cfg_data[7:0];
                REG_CYCLE_COUNT: n_cycle_count = i_cfg_data[7:0];
                REG_KEEP_CYCLES: n_keep_cycles = i_cfg_data;
                default: ;
            endcase
        end
    end

    // Slots after the transmit slot; a zero slot count gives zero
    assign w_span     = (r_slot_count == 8'd0) ? 8'd0 : r_slot_count - 8'd1;
    assign w_nid_prod = r_slot_ticks * r_node_id;

    // Hold registers; refresh products one multiply per register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id     <= RST_NODE_ID;
            r_slot_ticks  <= RST_SLOT_TICKS;
            r_slot_count  <= RST_SLOT_COUNT;
            r_cycle_count <= RST_CYCLE_COUNT;
            r_keep_cycles <= RST_KEEP_CYCLES;
            r_sccc        <= RST_SCCC;
            r_nid_ticks   <= RST_NID_TICKS;
            r_span_ticks  <= RST_SPAN_TICKS;
            r_sc_ticks    <= RST_SC_TICKS;
            r_total_ticks <= RST_TOTAL_TICKS;
        end else begin
            r_node_id     <= n_node_id;
            r_slot_ticks  <= n_slot_ticks;
            r_slot_count  <= n_slot_count;
            r_cycle_count <= n_cycle_count;
            r_keep_cycles <= n_keep_cycles;
            r_sccc        <= n_slot_count * n_cycle_count;
            r_nid_ticks   <= w_nid_prod[15:0];
            r_span_ticks  <= r_slot_ticks * w_span;
            r_sc_ticks    <= r_slot_ticks * r_slot_count;
            r_total_ticks <= r_slot_ticks * r_sccc;
        end
    end

    assign o_cfg.node_id     = r_node_id;
    assign o_cfg.slot_ticks  = r_slot_ticks;
    assign o_cfg.keep_cycles = r_keep_cycles;
    assign o_cfg.nid_ticks   = r_nid_ticks;
    assign o_cfg.span_ticks  = r_span_ticks;
    assign o_cfg.sc_ticks    = r_sc_ticks;
    assign o_cfg.total_ticks = r_total_ticks;

endmodule

`default_nettype wire

[sv/tss_step.sv]
// Event logic of the slot scheduler: slot state, time-source election and result fields.
// Depends on tss_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tss_step (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_advance,
    input  wire tss_pkg::t_cfg     i_cfg,
    input  wire tss_pkg::t_item    i_item,
    output tss_pkg::t_result       o_result
);
    import tss_pkg::*;

    logic        r_in_tx_slot,     n_in_tx_slot;
    logic [7:0]  r_time_source,    n_time_source;
    logic [15:0] r_source_timeout, n_source_timeout;
    logic [24:0] w_next;
    logic [25:0] w_next_end;
    logic        w_adopt;

    // End-of-slot compare, kept exact
    assign w_next     = {9'd0, i_item.tick} + {1'b0, i_cfg.span_ticks};
    assign w_next_end = {1'b0, w_next} + {10'd0, i_cfg.slot_ticks};

    // Election: lower source wins, tie goes to a lower sender than this node
    assign w_adopt = (i_item.pkt_source < r_time_source)
                  || ((i_item.pkt_source == r_time_source)
                      && (i_item.pkt_sender < i_cfg.node_id));

    always_comb begin
        n_in_tx_slot           = r_in_tx_slot;
        n_time_source          = r_time_source;
        n_source_timeout       = r_source_timeout;
        o_result.command       = CMD_NONE;
        o_result.compare_write = 1'b0;
        o_result.compare_value = 16'd0;
        o_result.counter_write = 1'b0;
        o_result.counter_value = 16'd0;
        case (i_item.op)
            OP_SUPERCYCLE: begin
                o_result.compare_write = 1'b1;
                if (i_cfg.node_id == 8'd0) begin
                    n_in_tx_slot           = 1'b1;
                    o_result.command       = CMD_TX;
                    o_result.compare_value = i_cfg.slot_ticks;
                end else begin
                    o_result.compare_value = i_cfg.nid_ticks;
                end
                // Age the foreign source, fall back to self when expired
                if (r_source_timeout != 16'd0) begin
                    n_source_timeout = r_source_timeout - 16'd1;
                end else begin
                    n_time_source = i_cfg.node_id;
                end
            end
            OP_MATCH: begin
                if (r_in_tx_slot) begin
                    n_in_tx_slot = 1'b0;
                    if ({6'd0, w_next_end} < i_cfg.total_ticks) begin
                        o_result.compare_write = 1'b1;
                        o_result.compare_value = w_next[15:0];
                    end
                    o_result.command = ({8'd0, i_item.tick} < i_cfg.sc_ticks) ?
                                       CMD_RX : CMD_SLEEP;
                end else begin
                    n_in_tx_slot           = 1'b1;
                    o_result.compare_write = 1'b1;
                    o_result.compare_value = i_item.tick + i_cfg.slot_ticks;
                    o_result.command       = CMD_TX;
                end
            end
            OP_PACKET: begin
                if (w_adopt) begin
                    o_result.counter_write = 1'b1;
                    o_result.counter_value = i_item.pkt_time + PKT_DELAY_TICKS;
                    n_time_source          = i_item.pkt_sender;
                    n_source_timeout       = i_cfg.keep_cycles;
                end
            end
            default: ;
        endcase
        o_result.source_id = n_time_source;
    end

    // Commit state when the event moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_tx_slot     <= 1'b0;
            r_time_source    <= 8'd0;
            r_source_timeout <= 16'd0;
        end else if (i_advance) begin
            r_in_tx_slot     <= n_in_tx_slot;
            r_time_source    <= n_time_source;
            r_source_timeout <= n_source_timeout;
        end
    end

    `TSS_ASSERT_NXT(a_adopt_arms_timeout, i_advance && (i_item.op == OP_PACKET) && w_adopt,
        r_source_timeout == $past(i_cfg.keep_cycles), "adopted packet did not arm timeout")
    `TSS_ASSERT_NXT(a_match_toggles_slot, i_advance && (i_item.op == OP_MATCH),
        r_in_tx_slot != $past(r_in_tx_slot), "compare match did not toggle slot state")
    `TSS_ASSERT_NXT(a_state_holds, !i_advance,
        $stable(r_time_source) && $stable(r_source_timeout) && $stable(r_in_tx_slot),
        "scheduler state changed without an event")

endmodule

`default_nettype wire

[sv/tdma_slot_scheduler.sv]
// Top level of the TDMA slot scheduler: stream ports, input and result registers.
// Depends on tss_pkg, tss_cfg, tss_step and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Takes one event beat per clock while the result side keeps taking result beats, and
// returns one result beat per event, in order. An event passes an input register
// and then a result register; it waits in the input register while the result
// register is full and not drained, so a full pipeline keeps one beat per cycle
// flowing as long as the result side takes them. The state update for an event
// happens as it moves into the result register, so consecutive events see each
// other's effect. Slot products (slot_ticks times node_id, slot count and cycle
// count) are recomputed in the cycle after a configuration write and are in place
// for any beat accepted from the next clock edge on.
module tdma_slot_scheduler (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write port
    input  wire logic                  i_cfg_we,
    input  wire tss_pkg::t_cfg_idx     i_cfg_idx,
    input  wire logic [15:0]           i_cfg_data,
    // event stream
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // [15:0] tick, [23:16] pkt_sender, [31:24] pkt_source, [47:32] pkt_time
    input  wire logic [47:0]           i_s_axis_tdata,
    // [1:0] operation
    input  wire logic [1:0]            i_s_axis_tuser,
    // result stream
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // [1:0] command, [2] compare_write, [18:3] compare_value, [19] counter_write,
    // [35:20] counter_value, [43:36] source_id, [47:44] zero
    output logic [47:0]                o_m_axis_tdata
);
    import tss_pkg::*;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    t_result w_result;
    t_cfg    w_cfg;
    logic    w_advance;
    logic    w_in_fire;

    tss_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    tss_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_cfg     (w_cfg),
        .i_item    (r_item),
        .o_result  (w_result)
    );

    // Move an event on when the result register is free or being drained
    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_in_fire       = i_s_axis_tvalid && o_s_axis_tready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_item.op         <= i_s_axis_tuser;
            r_item.tick       <= i_s_axis_tdata[15:0];
            r_item.pkt_sender <= i_s_axis_tdata[23:16];
            r_item.pkt_source <= i_s_axis_tdata[31:24];
            r_item.pkt_time   <= i_s_axis_tdata[47:32];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_result <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'd0, r_result.source_id, r_result.counter_value,
                              r_result.counter_write, r_result.compare_value,
                              r_result.compare_write, r_result.command};

    `TSS_ASSERT_IMP(a_stall_means_full, !o_s_axis_tready, r_in_valid && r_out_valid,
        "input stalled without a full pipeline")
    `TSS_ASSERT_NXT(a_result_kept, r_out_valid && !i_m_axis_tready, r_out_valid,
        "result dropped while stalled")
    `TSS_ASSERT_NXT(a_event_lands, w_advance, r_out_valid,
        "event advanced but no result registered")

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Testbench for tdma_slot_scheduler: drives event beats and checks every result beat
// against a scheduler predictor that lives in a small tracker class. Depends on tss_pkg
// and on the RTL of the scheduler.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tss_pkg::*;

    localparam int unsigned CLK_PERIOD = 12;

    // Predict scheduler results and match them against the result stream
    class schedule_tracker;
        logic [7:0]  node_id;
        logic [15:0] slot_ticks;
        logic [7:0]  slot_count;
        logic [7:0]  cycle_count;
        logic [15:0] keep_cycles;
        bit          in_tx_slot;
        logic [7:0]  time_source;
        logic [15:0] source_timeout;
        logic [15:0] last_compare;
        t_result     due_results[$];
        int unsigned mismatches;

        function new();
            node_id        = RST_NODE_ID;
            slot_ticks     = RST_SLOT_TICKS;
            slot_count     = RST_SLOT_COUNT;
            cycle_count    = RST_CYCLE_COUNT;
            keep_cycles    = RST_KEEP_CYCLES;
            in_tx_slot     = 1'b0;
            time_source    = 8'd0;
            source_timeout = 16'd0;
            last_compare   = 16'd0;
            mismatches     = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [15:0] data);
            case (idx)
                REG_NODE_ID:     node_id     = data[7:0];
                REG_SLOT_TICKS:  slot_ticks  = data;
                REG_SLOT_COUNT:  slot_count  = data[7:0];
                REG_CYCLE_COUNT: cycle_count = data[7:0];
                REG_KEEP_CYCLES: keep_cycles = data;
                default: ;
            endcase
        endfunction

        // Work out the result of one accepted event and advance the state
        function void accept_event(t_item ev);
            t_result r;
            longint unsigned st, tk, span, next_cmp, total;
            r        = '0;
            st       = slot_ticks;
            tk       = ev.tick;
            case (ev.op)
                OP_SUPERCYCLE: begin
                    if (node_id == 8'd0) begin
                        in_tx_slot      = 1'b1;
                        r.command       = CMD_TX;
                        r.compare_value = slot_ticks;
                    end else begin
                        r.compare_value = 16'(st * node_id);
                    end
                    r.compare_write = 1'b1;
                    if (source_timeout != 16'd0)
                        source_timeout = source_timeout - 16'd1;
                    else
                        time_source = node_id;
                end
                OP_MATCH: begin
                    if (in_tx_slot) begin
                        // end of the transmit slot: all sums exact, no wrap
                        span       = (slot_count != 8'd0) ? slot_count - 1 : 0;
                        next_cmp   = tk + span * st;
                        total      = st * slot_count * cycle_count;
                        in_tx_slot = 1'b0;
                        if (next_cmp + st < total) begin
                            r.compare_write = 1'b1;
                            r.compare_value = 16'(next_cmp);
                        end
                        r.command = (tk < st * slot_count) ? CMD_RX : CMD_SLEEP;
                    end else begin
                        in_tx_slot      = 1'b1;
                        r.compare_write = 1'b1;
                        r.compare_value = 16'(tk + st);
                        r.command       = CMD_TX;
                    end
                end
                OP_PACKET: begin
                    // adopt a better time source; its sender becomes the source
                    if (ev.pkt_source < time_source ||
                        (ev.pkt_source == time_source && ev.pkt_sender < node_id)) begin
                        r.counter_write = 1'b1;
                        r.counter_value = ev.pkt_time + PKT_DELAY_TICKS;
                        time_source     = ev.pkt_sender;
                        source_timeout  = keep_cycles;
                    end
                end
                default: ;
            endcase
            r.source_id = time_source;
            if (r.compare_write)
                last_compare = r.compare_value;
            due_results.push_back(r);
        endfunction

        function void check_field(string label, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %0h got %0h", $time, label, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                $display("%0t: result beat with nothing expected, got %h", $time, got);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            check_field("command", want.command, got.command);
            check_field("compare_write", want.compare_write, got.compare_write);
            check_field("compare_value", want.compare_value, got.compare_value);
            check_field("counter_write", want.counter_write, got.counter_write);
            check_field("counter_value", want.counter_value, got.counter_value);
            check_field("source_id", want.source_id, got.source_id);
        endfunction

        function void check_drained();
            if (due_results.size() != 0) begin
                $display("%0t: %0d results never arrived", $time, due_results.size());
                mismatches += due_results.size();
            end
        endfunction
    endclass

    logic             i_clk           = 1'b0;
    logic             i_rst_n         = 1'b0;
    logic             i_cfg_we        = 1'b0;
    t_cfg_idx         i_cfg_idx       = REG_NODE_ID;
    logic [15:0]      i_cfg_data      = 16'd0;
    logic             i_s_axis_tvalid = 1'b0;
    logic             o_s_axis_tready;
    // [15:0] tick, [23:16] pkt_sender, [31:24] pkt_source, [47:32] pkt_time
    logic [47:0]      i_s_axis_tdata  = 48'd0;
    // [1:0] operation
    logic [1:0]       i_s_axis_tuser  = 2'd0;
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready = 1'b0;
    // [1:0] command, [2] compare_write, [18:3] compare_value, [19] counter_write,
    // [35:20] counter_value, [43:36] source_id, [47:44] zero
    logic [47:0]      o_m_axis_tdata;

    schedule_tracker  tracker;
    int unsigned      events_sent    = 0;
    int unsigned      results_seen   = 0;
    bit               no_gaps        = 1'b0;
    bit               long_hold_done = 1'b0;

    tdma_slot_scheduler DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one
    function automatic int unsigned idle_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_item make_event(t_op op, logic [15:0] tick, logic [7:0] sender,
                                         logic [7:0] source, logic [15:0] ptime);
        t_item ev;
        ev.op         = op;
        ev.tick       = tick;
        ev.pkt_sender = sender;
        ev.pkt_source = source;
        ev.pkt_time   = ptime;
        return ev;
    endfunction

    function automatic t_item noise_item();
        return make_event(t_op'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          16'($urandom_range(0, 65535)));
    endfunction

    // Packet whose source often sits near the current time source, so elections go both ways
    function automatic t_item rand_packet();
        t_item      ev;
        logic [7:0] ts;
        ev    = noise_item();
        ev.op = OP_PACKET;
        ts    = tracker.time_source;
        case ($urandom_range(0, 5))
            0: ev.pkt_source = ts - 8'd1;
            1: ev.pkt_source = ts;
            2: ev.pkt_source = ts + 8'd1;
            3: ev.pkt_source = 8'd0;
            4: ev.pkt_source = 8'hFF;
            default: ;
        endcase
        if ($urandom_range(0, 1))
            ev.pkt_sender = 8'($urandom_range(0, tracker.node_id));
        return ev;
    endfunction

    // Offer one event beat, hold it until accepted, then maybe idle
    task automatic send_event(input t_item ev);
        int unsigned pause;
        @(negedge i_clk);
        i_s_axis_tdata  = {ev.pkt_time, ev.pkt_source, ev.pkt_sender, ev.tick};
        i_s_axis_tuser  = ev.op;
        i_s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        tracker.accept_event(ev);
        events_sent++;
        pause = no_gaps ? 0 : idle_cycles();
        if (pause > 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
            repeat (pause - 1) @(negedge i_clk);
        end
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic settle();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (tracker.due_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        tracker.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic load_config(input logic [7:0] node, input logic [15:0] ticks,
                               input logic [7:0] slots, input logic [7:0] cycles,
                               input logic [15:0] keep);
        settle();
        write_reg(REG_NODE_ID, {8'd0, node});
        write_reg(REG_SLOT_TICKS, ticks);
        write_reg(REG_SLOT_COUNT, {8'd0, slots});
        write_reg(REG_CYCLE_COUNT, {8'd0, cycles});
        write_reg(REG_KEEP_CYCLES, keep);
    endtask

    // Supercycle start followed by compare matches, most near the armed compare, and now and then a packet
    task automatic run_superframe();
        t_item       ev;
        int unsigned match_beats;
        ev    = noise_item();
        ev.op = OP_SUPERCYCLE;
        send_event(ev);
        match_beats = $urandom_range(1, 8);
        repeat (match_beats) begin
            if ($urandom_range(0, 9) == 0) begin
                send_event(rand_packet());
            end else begin
                ev    = noise_item();
                ev.op = OP_MATCH;
                if ($urandom_range(0, 7) != 0)
                    ev.tick = tracker.last_compare + 16'($urandom_range(0, 1));
                send_event(ev);
            end
        end
    endtask

    task automatic run_phase(input int unsigned count, input bit drain_midway);
        int unsigned start, r;
        bit          drained;
        t_item       ev;
        start   = events_sent;
        drained = 1'b0;
        while (events_sent - start < count) begin
            // open each phase with a stretch of back-to-back beats
            no_gaps = (events_sent - start) < 40;
            if (drain_midway && !drained && events_sent - start >= count / 2) begin
                settle();
                drained = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 65) begin
                run_superframe();
            end else if (r < 80) begin
                send_event(rand_packet());
            end else begin
                ev = noise_item();
                if (r < 92)
                    ev.op = OP_MATCH;
                else if (r < 97)
                    ev.op = OP_SUPERCYCLE;
                send_event(ev);
            end
        end
        no_gaps = 1'b0;
    endtask

    // Check every result beat taken by the receiver
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            tracker.check_result(t_result'({o_m_axis_tdata[1:0], o_m_axis_tdata[2],
                                            o_m_axis_tdata[18:3], o_m_axis_tdata[19],
                                            o_m_axis_tdata[35:20], o_m_axis_tdata[43:36]}));
            results_seen++;
        end
    end

    // Receiver: ready runs and stalls, plus one long hold-off that fills the block
    initial begin
        int unsigned run;
        wait (i_rst_n);
        forever begin
            if (!long_hold_done && results_seen >= 300 && i_s_axis_tvalid) begin
                long_hold_done = 1'b1;
                @(negedge i_clk);
                i_m_axis_tready = 1'b0;
                repeat (300) @(negedge i_clk);
            end
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
            @(negedge i_clk);
            i_m_axis_tready = 1'b1;
            repeat (run - 1) @(negedge i_clk);
            run = idle_cycles();
            if (run > 0) begin
                @(negedge i_clk);
                i_m_axis_tready = 1'b0;
                repeat (run - 1) @(negedge i_clk);
            end
        end
    end

    // Stimulus
    initial begin
        int unsigned guard;
        tracker = new();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset configuration: node 0 transmits at once
        send_event(make_event(OP_SUPERCYCLE, 16'd0, 8'd0, 8'd0, 16'd0));
        send_event(make_event(OP_MATCH, 16'd100, 8'd0, 8'd0, 16'd0));
        send_event(make_event(OP_MATCH, 16'd400, 8'd0, 8'd0, 16'd0));
        send_event(make_event(OP_MATCH, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF));
        // compare past sixteen bits wraps
        send_event(make_event(OP_MATCH, 16'hFFFF, 8'd0, 8'd0, 16'd0));
        send_event(make_event(OP_MATCH, 16'd0, 8'd0, 8'd0, 16'd0));
        send_event(make_event(OP_PACKET, 16'hFFFF, 8'hFF, 8'd0, 16'hFFFF));
        send_event(make_event(OP_PACKET, 16'd0, 8'd0, 8'hFF, 16'd0));
        // unknown operation changes nothing
        send_event(make_event(t_op'(2'd3), 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF));
        send_event(make_event(OP_SUPERCYCLE, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF));
        send_event(make_event(OP_MATCH, 16'd0, 8'd0, 8'd0, 16'd0));
        send_event(make_event(OP_MATCH, 16'd399, 8'd0, 8'd0, 16'd0));

        // foreign time source: election, refresh and timeout
        settle();
        write_reg(REG_NODE_ID, 16'd5);
        write_reg(REG_KEEP_CYCLES, 16'd1);
        send_event(make_event(OP_SUPERCYCLE, 16'd0, 8'd0, 8'd0, 16'd0));
        send_event(make_event(OP_PACKET, 16'd0, 8'd9, 8'd4, 16'hFFFF));
        send_event(make_event(OP_PACKET, 16'd0, 8'd4, 8'd9, 16'd1234));
        send_event(make_event(OP_PACKET, 16'd0, 8'd200, 8'd9, 16'd1));
        send_event(make_event(OP_PACKET, 16'd0, 8'd3, 8'd4, 16'd2));
        send_event(make_event(OP_SUPERCYCLE, 16'd0, 8'd0, 8'd0, 16'd0));
        send_event(make_event(OP_SUPERCYCLE, 16'd0, 8'd0, 8'd0, 16'd0));
        send_event(make_event(OP_PACKET, 16'd0, 8'd0, 8'd0, 16'd0));
        send_event(make_event(OP_MATCH, 16'd500, 8'd0, 8'd0, 16'd0));
        send_event(make_event(OP_MATCH, 16'd600, 8'd0, 8'd0, 16'd0));

        // random phases over several configurations, extremes included
        load_config(8'd3, 16'd100, 8'd8, 8'd2, 16'd2);
        run_phase(150, 1'b0);
        load_config(8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF);
        run_phase(150, 1'b0);
        load_config(8'd0, 16'd1, 8'd1, 8'd1, 16'd0);
        run_phase(150, 1'b1);
        // zero slot count
        load_config(8'($urandom_range(0, 255)), 16'($urandom_range(1, 4000)), 8'd0,
                    8'($urandom_range(1, 255)), 16'd1);
        run_phase(150, 1'b0);
        load_config(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    16'($urandom_range(0, 3)));
        run_phase(150, 1'b0);
        load_config(8'($urandom_range(1, 254)), 16'd0, 8'($urandom_range(0, 255)), 8'd0,
                    16'd2);
        run_phase(100, 1'b0);

        // drain and report
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        guard = 0;
        while (tracker.due_results.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
        tracker.check_drained();
        if (tracker.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Hard stop if the run hangs
    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
+incdir+sv
sv/tss_pkg.sv
sv/tss_cfg.sv
sv/tss_step.sv
sv/tdma_slot_scheduler.sv
tb/sv/tb.sv
